// ===== hw/rtl/les_pkg.sv =====
// les_pkg: shared types, constants and the control program of the lorenz euler step block
// depends on nothing; imported by les_sequencer, les_datapath and lorenz_euler_step

package les_pkg;

	// default sizes of the top level parameters
	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 24;

	// fixed field widths
	localparam int TIME_W     = 41;
	localparam int STEP_W     = 25;
	localparam int INDEX_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int TPROD_W    = INDEX_W + STEP_W;
	localparam int TSUM_W     = TPROD_W + 2;

	// operand width of the datapath, product digit size
	localparam int OPND_W         = 64;
	localparam int DIGIT_W        = 16;
	localparam int NUM_DIGITS_DEF = 2;

	// reset value of the run length
	localparam int MAX_STEPS_RST = 30001;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SIGMA      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RHO        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS  = 3'd5;

	// item kind on the input side
	localparam logic FUNC_RESTART = 1'b0;

	// datapath operations
	localparam logic [1:0] OP_NOP = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MAC = 2'd2;
	localparam logic [1:0] OP_UPD = 2'd3;

	// operand sources
	localparam logic [2:0] SRC_X    = 3'd0;
	localparam logic [2:0] SRC_Y    = 3'd1;
	localparam logic [2:0] SRC_Z    = 3'd2;
	localparam logic [2:0] SRC_T0   = 3'd3;
	localparam logic [2:0] SRC_T1   = 3'd4;
	localparam logic [2:0] SRC_T2   = 3'd5;
	localparam logic [2:0] SRC_P    = 3'd6;
	localparam logic [2:0] SRC_ZERO = 3'd7;

	// multiplier digit sources
	localparam logic [2:0] MSEL_SIGMA = 3'd0;
	localparam logic [2:0] MSEL_RHO   = 3'd1;
	localparam logic [2:0] MSEL_BETA  = 3'd2;
	localparam logic [2:0] MSEL_STEP  = 3'd3;
	localparam logic [2:0] MSEL_Y     = 3'd4;
	localparam logic [2:0] MSEL_Z     = 3'd5;

	// destinations
	localparam logic [2:0] DST_T0 = 3'd0;
	localparam logic [2:0] DST_T1 = 3'd1;
	localparam logic [2:0] DST_T2 = 3'd2;
	localparam logic [2:0] DST_X  = 3'd3;
	localparam logic [2:0] DST_Y  = 3'd4;
	localparam logic [2:0] DST_Z  = 3'd5;

	// program counter
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_EMIT = 5'd18;

	// one control word of the program
	typedef struct packed {
		logic [1:0] op;
		logic [2:0] asel;
		logic [2:0] bsel;
		logic [2:0] msel;
		logic [2:0] dst;
		logic       loop;
		logic       tmul;
		logic       tupd;
		logic       done;
	} ucode_t;

	// control issued by the sequencer in the current cycle
	typedef struct packed {
		logic [1:0] op;
		logic [2:0] asel;
		logic [2:0] bsel;
		logic [2:0] msel;
		logic [2:0] dst;
		logic       first;
		logic       tmul;
		logic       tupd;
		logic       done;
	} ctrl_t;

	function automatic ucode_t uc_word(input logic [1:0] op, input logic [2:0] asel,
			input logic [2:0] bsel, input logic [2:0] msel, input logic [2:0] dst,
			input logic loop, input logic tmul, input logic tupd, input logic done);
		ucode_t w;
		w.op   = op;
		w.asel = asel;
		w.bsel = bsel;
		w.msel = msel;
		w.dst  = dst;
		w.loop = loop;
		w.tmul = tmul;
		w.tupd = tupd;
		w.done = done;
		return w;
	endfunction

	// program rom: derivatives first, then the three coordinate updates
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			// t0 = y - x, start the time product
			5'd0:  w = uc_word(OP_SUB, SRC_Y, SRC_X, MSEL_SIGMA, DST_T0, 1'b0, 1'b1, 1'b0, 1'b0);
			// dx = sigma * t0
			5'd1:  w = uc_word(OP_MAC, SRC_T0, SRC_ZERO, MSEL_SIGMA, DST_T0, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd2:  w = uc_word(OP_SUB, SRC_P, SRC_ZERO, MSEL_SIGMA, DST_T0, 1'b0, 1'b0, 1'b0, 1'b0);
			// dy = rho * x - x * z - y
			5'd3:  w = uc_word(OP_MAC, SRC_X, SRC_ZERO, MSEL_RHO, DST_T1, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd4:  w = uc_word(OP_SUB, SRC_P, SRC_ZERO, MSEL_RHO, DST_T1, 1'b0, 1'b0, 1'b0, 1'b0);
			5'd5:  w = uc_word(OP_MAC, SRC_X, SRC_ZERO, MSEL_Z, DST_T1, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd6:  w = uc_word(OP_SUB, SRC_T1, SRC_P, MSEL_Z, DST_T1, 1'b0, 1'b0, 1'b0, 1'b0);
			5'd7:  w = uc_word(OP_SUB, SRC_T1, SRC_Y, MSEL_Z, DST_T1, 1'b0, 1'b0, 1'b0, 1'b0);
			// dz = x * y - beta * z
			5'd8:  w = uc_word(OP_MAC, SRC_X, SRC_ZERO, MSEL_Y, DST_T2, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd9:  w = uc_word(OP_SUB, SRC_P, SRC_ZERO, MSEL_Y, DST_T2, 1'b0, 1'b0, 1'b0, 1'b0);
			5'd10: w = uc_word(OP_MAC, SRC_Z, SRC_ZERO, MSEL_BETA, DST_T2, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd11: w = uc_word(OP_SUB, SRC_T2, SRC_P, MSEL_BETA, DST_T2, 1'b0, 1'b0, 1'b0, 1'b0);
			// x += h * dx
			5'd12: w = uc_word(OP_MAC, SRC_T0, SRC_ZERO, MSEL_STEP, DST_X, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd13: w = uc_word(OP_UPD, SRC_X, SRC_P, MSEL_STEP, DST_X, 1'b0, 1'b0, 1'b0, 1'b0);
			// y += h * dy
			5'd14: w = uc_word(OP_MAC, SRC_T1, SRC_ZERO, MSEL_STEP, DST_Y, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd15: w = uc_word(OP_UPD, SRC_Y, SRC_P, MSEL_STEP, DST_Y, 1'b0, 1'b0, 1'b0, 1'b0);
			// z += h * dz, settle the sample time
			5'd16: w = uc_word(OP_MAC, SRC_T2, SRC_ZERO, MSEL_STEP, DST_Z, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd17: w = uc_word(OP_UPD, SRC_Z, SRC_P, MSEL_STEP, DST_Z, 1'b0, 1'b0, 1'b1, 1'b0);
			// hand the sample to the output register
			default: w = uc_word(OP_NOP, SRC_ZERO, SRC_ZERO, MSEL_STEP, DST_T0,
				1'b0, 1'b0, 1'b0, 1'b1);
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/les_sequencer.sv =====
// les_sequencer: program counter, digit counter and control rom lookup
// depends on les_pkg (control word types and the program)

module les_sequencer #(
	parameter int NUM_DIGITS = les_pkg::NUM_DIGITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           start_emit,
	input  logic           out_free,
	output logic           busy,
	output les_pkg::ctrl_t ctrl
);
	import les_pkg::*;

	localparam int DIG_W = $clog2(NUM_DIGITS);
	localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(NUM_DIGITS - 1);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic [DIG_W-1:0] dig_q;
	ucode_t          word;

	assign word = ucode(pc_q);
	assign busy = busy_q;

	// issue the current word while running
	always_comb begin
		ctrl = '0;
		ctrl.op = OP_NOP;
		if (busy_q) begin
			ctrl.op    = word.op;
			ctrl.asel  = word.asel;
			ctrl.bsel  = word.bsel;
			ctrl.msel  = word.msel;
			ctrl.dst   = word.dst;
			ctrl.first = (dig_q == '0);
			ctrl.tmul  = word.tmul;
			ctrl.tupd  = word.tupd;
			ctrl.done  = word.done && out_free;
		end
	end

	// program counter with entry dispatch, digit loop and stall on the final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			dig_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= start_emit ? PC_EMIT : '0;
			dig_q  <= '0;
		end else if (busy_q) begin
			if (word.done) begin
				if (out_free) begin
					busy_q <= 1'b0;
				end
			end else if (word.loop && dig_q != DIG_LAST) begin
				dig_q <= dig_q + 1'b1;
			end else begin
				dig_q <= '0;
				pc_q  <= pc_q + 1'b1;
			end
		end
	end

	// the digit counter only runs on a looping word
	a_dig_loop: assert property (@(posedge clk) disable iff (!arst_n)
		dig_q != '0 |-> busy_q && word.loop)
		else $error("digit counter active outside a multiply word");

endmodule

// ===== hw/rtl/les_datapath.sv =====
// les_datapath: coordinate registers, temporaries, digit serial multiply accumulate,
// saturating subtract and coordinate update; depends on les_pkg

module les_datapath #(
	parameter int WORD_WIDTH = les_pkg::WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = les_pkg::FRAC_BITS_DEF,
	parameter int NUM_DIGITS = les_pkg::NUM_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  les_pkg::ctrl_t                     ctrl,
	input  logic                               load,
	input  logic                               clear,
	input  logic signed [WORD_WIDTH-1:0]       init_x,
	input  logic signed [WORD_WIDTH-1:0]       init_y,
	input  logic signed [WORD_WIDTH-1:0]       init_z,
	input  logic signed [WORD_WIDTH-1:0]       sigma,
	input  logic signed [WORD_WIDTH-1:0]       rho,
	input  logic signed [WORD_WIDTH-1:0]       beta,
	input  logic        [les_pkg::STEP_W-1:0]  step_size,
	output logic signed [WORD_WIDTH-1:0]       pos_x,
	output logic signed [WORD_WIDTH-1:0]       pos_y,
	output logic signed [WORD_WIDTH-1:0]       pos_z,
	output logic                               overflow
);
	import les_pkg::*;

	localparam int MW     = NUM_DIGITS * DIGIT_W;
	localparam int AW     = OPND_W + MW;
	localparam int PROD_W = OPND_W + DIGIT_W + 1;

	localparam logic signed [OPND_W-1:0] S64_MAX = {1'b0, {(OPND_W-1){1'b1}}};
	localparam logic signed [OPND_W-1:0] S64_MIN = {1'b1, {(OPND_W-1){1'b0}}};
	localparam logic signed [WORD_WIDTH-1:0] SW_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic signed [WORD_WIDTH-1:0] SW_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	logic signed [WORD_WIDTH-1:0] x_q, y_q, z_q;
	logic signed [OPND_W-1:0]     t0_q, t1_q, t2_q;
	logic signed [AW-1:0]         acc_q;
	logic        [MW-1:0]         mreg_q;
	logic                         ovf_q;

	logic signed [AW-1:0]         acc_shr;
	logic signed [OPND_W-1:0]     mul_res;
	logic signed [OPND_W-1:0]     opa, opb;
	logic signed [MW-1:0]         msrc;
	logic signed [DIGIT_W:0]      digit;
	logic signed [PROD_W-1:0]     prod;
	logic signed [AW-1:0]         acc_next;
	logic signed [OPND_W:0]       diff, sum;
	logic signed [OPND_W-1:0]     sub_res;
	logic signed [WORD_WIDTH-1:0] upd_res;
	logic                         upd_hit;

	// product scaled back by the fraction bits and saturated to 64 bits
	always_comb begin
		acc_shr = acc_q >>> FRAC_BITS;
		if ((&acc_shr[AW-1:OPND_W-1]) || !(|acc_shr[AW-1:OPND_W-1])) begin
			mul_res = acc_shr[OPND_W-1:0];
		end else begin
			mul_res = acc_shr[AW-1] ? S64_MIN : S64_MAX;
		end
	end

	// operand a
	always_comb begin
		case (ctrl.asel)
			SRC_X:   opa = OPND_W'(x_q);
			SRC_Y:   opa = OPND_W'(y_q);
			SRC_Z:   opa = OPND_W'(z_q);
			SRC_T0:  opa = t0_q;
			SRC_T1:  opa = t1_q;
			SRC_T2:  opa = t2_q;
			SRC_P:   opa = mul_res;
			default: opa = '0;
		endcase
	end

	// operand b
	always_comb begin
		case (ctrl.bsel)
			SRC_X:   opb = OPND_W'(x_q);
			SRC_Y:   opb = OPND_W'(y_q);
			SRC_Z:   opb = OPND_W'(z_q);
			SRC_T0:  opb = t0_q;
			SRC_T1:  opb = t1_q;
			SRC_T2:  opb = t2_q;
			SRC_P:   opb = mul_res;
			default: opb = '0;
		endcase
	end

	// multiplier digit source
	always_comb begin
		case (ctrl.msel)
			MSEL_SIGMA: msrc = MW'(sigma);
			MSEL_RHO:   msrc = MW'(rho);
			MSEL_BETA:  msrc = MW'(beta);
			MSEL_STEP:  msrc = MW'({1'b0, step_size});
			MSEL_Y:     msrc = MW'(y_q);
			MSEL_Z:     msrc = MW'(z_q);
			default:    msrc = '0;
		endcase
	end

	// horner accumulation, most significant (signed) digit first
	always_comb begin
		if (ctrl.first) begin
			digit = (DIGIT_W + 1)'($signed(msrc[MW-1 -: DIGIT_W]));
		end else begin
			digit = $signed({1'b0, mreg_q[MW-1 -: DIGIT_W]});
		end
		prod = opa * digit;
		if (ctrl.first) begin
			acc_next = AW'(prod);
		end else begin
			acc_next = (acc_q <<< DIGIT_W) + AW'(prod);
		end
	end

	// saturating subtract and clamped coordinate update
	always_comb begin
		diff = (OPND_W + 1)'(opa) - (OPND_W + 1)'(opb);
		if (diff[OPND_W] != diff[OPND_W-1]) begin
			sub_res = diff[OPND_W] ? S64_MIN : S64_MAX;
		end else begin
			sub_res = diff[OPND_W-1:0];
		end
		sum = (OPND_W + 1)'(opa) + (OPND_W + 1)'(opb);
		if ((&sum[OPND_W:WORD_WIDTH-1]) || !(|sum[OPND_W:WORD_WIDTH-1])) begin
			upd_res = sum[WORD_WIDTH-1:0];
			upd_hit = 1'b0;
		end else begin
			upd_res = sum[OPND_W] ? SW_MIN : SW_MAX;
			upd_hit = 1'b1;
		end
	end

	// coordinates and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			z_q   <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (load) begin
				x_q <= init_x;
				y_q <= init_y;
				z_q <= init_z;
			end else if (ctrl.op == OP_UPD) begin
				if (ctrl.dst == DST_X) x_q <= upd_res;
				if (ctrl.dst == DST_Y) y_q <= upd_res;
				if (ctrl.dst == DST_Z) z_q <= upd_res;
			end
			if (clear) begin
				ovf_q <= 1'b0;
			end else if (ctrl.op == OP_UPD && upd_hit) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// temporaries, accumulator and digit shifter
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_SUB) begin
			if (ctrl.dst == DST_T0) t0_q <= sub_res;
			if (ctrl.dst == DST_T1) t1_q <= sub_res;
			if (ctrl.dst == DST_T2) t2_q <= sub_res;
		end
		if (ctrl.op == OP_MAC) begin
			acc_q <= acc_next;
			if (ctrl.first) begin
				mreg_q <= msrc << DIGIT_W;
			end else begin
				mreg_q <= mreg_q << DIGIT_W;
			end
		end
	end

	assign pos_x    = x_q;
	assign pos_y    = y_q;
	assign pos_z    = z_q;
	assign overflow = ovf_q;

	// saturation is only flagged by a coordinate update
	a_ovf_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> $past(ctrl.op) == OP_UPD)
		else $error("overflow flag set outside a coordinate update");

endmodule

// ===== hw/rtl/lorenz_euler_step.sv =====
// lorenz_euler_step: top level with stream ports, configuration registers, sample
// index and time, and the output register; uses les_pkg, les_sequencer, les_datapath
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata: init_x, init_y, init_z; tuser: func
// m_        out  m_tvalid/m_tready  tdata: pos_x, pos_y, pos_z, sample_time, sample_index;
//                                   tlast: last; tuser: overflow
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// a step item keeps the sequencer busy through eight products on one 64 x 17 bit
// multiply accumulate unit, one 16 bit digit per cycle, plus the subtract and update
// steps of the program
// restart items and steps at the end of a run only issue the final program word
// s_tready is high whenever the sequencer is idle, also while a result waits in m_
// the final program word stalls while the output register is full and not taken
// arst_n clears the point, index, time and flags and loads the default registers

module lorenz_euler_step #(
	parameter int WORD_WIDTH = les_pkg::WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = les_pkg::FRAC_BITS_DEF,
	localparam int IN_DW  = ((3 * WORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_DW = ((3 * WORD_WIDTH + les_pkg::TIME_W + les_pkg::INDEX_W + 7) / 8) * 8,
	localparam int CFG_W  = (WORD_WIDTH > les_pkg::TIME_W) ? WORD_WIDTH : les_pkg::TIME_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input item
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [IN_DW-1:0]                  s_tdata,   // init_x, init_y, init_z
	input  logic                              s_tuser,   // func
	// result item
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [OUT_DW-1:0]                 m_tdata,   // pos_x, pos_y, pos_z, sample_time, sample_index
	output logic                              m_tuser,   // overflow
	output logic                              m_tlast,
	// configuration writes
	input  logic                              cfg_wr_en,
	input  logic [les_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]                  cfg_wdata
);
	import les_pkg::*;

	localparam int MUL_BITS   = (WORD_WIDTH > STEP_W) ? WORD_WIDTH : STEP_W + 1;
	localparam int NUM_DIGITS = (MUL_BITS + DIGIT_W - 1) / DIGIT_W;

	localparam logic [63:0] SIGMA_RST = 64'(10) << FRAC_BITS;
	localparam logic [63:0] RHO_RST   = 64'(28) << FRAC_BITS;
	localparam logic [63:0] BETA_RST  = (64'(8) << FRAC_BITS) / 3;
	localparam logic [63:0] STEP_RST  = (64'(1) << FRAC_BITS) / 1000;

	// configuration registers
	logic signed [WORD_WIDTH-1:0] sigma_q, rho_q, beta_q;
	logic        [STEP_W-1:0]     step_size_q;
	logic signed [TIME_W-1:0]     start_time_q;
	logic        [STEP_W-1:0]     max_steps_q;

	// run state and output register
	logic        [INDEX_W-1:0]    idx_q;
	logic signed [TIME_W-1:0]     time_q;
	logic        [TPROD_W-1:0]    tprod_q;
	logic                         m_tvalid_q;
	logic signed [WORD_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
	logic signed [TIME_W-1:0]     out_time_q;
	logic        [INDEX_W-1:0]    out_idx_q;
	logic                         out_last_q, out_ovf_q;

	logic                         s_fire, restart, at_last, out_free, busy;
	logic        [STEP_W-1:0]     last_idx;
	logic signed [TSUM_W-1:0]     tsum;
	logic signed [TIME_W-1:0]     time_clamped;
	logic signed [WORD_WIDTH-1:0] pos_x, pos_y, pos_z;
	logic                         overflow;
	ctrl_t                        ctrl;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q      <= SIGMA_RST[WORD_WIDTH-1:0];
			rho_q        <= RHO_RST[WORD_WIDTH-1:0];
			beta_q       <= BETA_RST[WORD_WIDTH-1:0];
			step_size_q  <= STEP_RST[STEP_W-1:0];
			start_time_q <= '0;
			max_steps_q  <= STEP_W'(MAX_STEPS_RST);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SIGMA:      sigma_q      <= cfg_wdata[WORD_WIDTH-1:0];
				REG_RHO:        rho_q        <= cfg_wdata[WORD_WIDTH-1:0];
				REG_BETA:       beta_q       <= cfg_wdata[WORD_WIDTH-1:0];
				REG_STEP_SIZE:  step_size_q  <= cfg_wdata[STEP_W-1:0];
				REG_START_TIME: start_time_q <= cfg_wdata[TIME_W-1:0];
				REG_MAX_STEPS:  max_steps_q  <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// input transfer and run position
	assign s_tready = !busy;
	assign s_fire   = s_tvalid && s_tready;
	assign restart  = (s_tuser == FUNC_RESTART);
	assign last_idx = (max_steps_q == '0) ? '0 : max_steps_q - 1'b1;
	assign at_last  = ({1'b0, idx_q} >= last_idx);
	assign out_free = !m_tvalid_q || m_tready;

	// sample time from the index, clamped to the time width
	always_comb begin
		tsum = TSUM_W'(start_time_q) + $signed({2'b00, tprod_q});
		if ((&tsum[TSUM_W-1:TIME_W-1]) || !(|tsum[TSUM_W-1:TIME_W-1])) begin
			time_clamped = tsum[TIME_W-1:0];
		end else begin
			time_clamped = tsum[TSUM_W-1] ? {1'b1, {(TIME_W-1){1'b0}}}
				: {1'b0, {(TIME_W-1){1'b1}}};
		end
	end

	// index and time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			time_q <= '0;
		end else begin
			if (s_fire) begin
				if (restart) begin
					idx_q  <= '0;
					time_q <= start_time_q;
				end else if (!at_last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (ctrl.tupd) begin
				time_q <= time_clamped;
			end
		end
	end

	// index times step, taken once the index has advanced
	always_ff @(posedge clk) begin
		if (ctrl.tmul) begin
			tprod_q <= TPROD_W'(idx_q) * TPROD_W'(step_size_q);
		end
	end

	les_sequencer #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (s_fire),
		.start_emit (restart || at_last),
		.out_free   (out_free),
		.busy       (busy),
		.ctrl       (ctrl)
	);

	les_datapath #(
		.WORD_WIDTH (WORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.NUM_DIGITS (NUM_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.load      (s_fire && restart),
		.clear     (s_fire),
		.init_x    (s_tdata[WORD_WIDTH-1:0]),
		.init_y    (s_tdata[2*WORD_WIDTH-1:WORD_WIDTH]),
		.init_z    (s_tdata[3*WORD_WIDTH-1:2*WORD_WIDTH]),
		.sigma     (sigma_q),
		.rho       (rho_q),
		.beta      (beta_q),
		.step_size (step_size_q),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.overflow  (overflow)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctrl.done) begin
			out_x_q    <= pos_x;
			out_y_q    <= pos_y;
			out_z_q    <= pos_z;
			out_time_q <= time_q;
			out_idx_q  <= idx_q;
			out_last_q <= at_last;
			out_ovf_q  <= overflow;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DW'({out_idx_q, out_time_q, out_z_q, out_y_q, out_x_q});
	assign m_tuser  = out_ovf_q;
	assign m_tlast  = out_last_q;

	// a restart puts the run back at index zero and the start time
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tuser == FUNC_RESTART |=> idx_q == '0 && time_q == $past(start_time_q))
		else $error("restart did not reset index and time");

	// a result appears only after the final program word issued
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(ctrl.done))
		else $error("output valid without a finished item");

endmodule
